FILE: rtl/pfs_pkg.sv
// pfs_pkg: shared types and constants for the palette fade stepper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pfs_pkg;

    typedef enum logic [2:0] {
        ACT_WR_CUR = 3'd0,
        ACT_WR_TGT = 3'd1,
        ACT_START  = 3'd2,
        ACT_TICK   = 3'd3,
        ACT_RD_CUR = 3'd4
    } t_action;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DIV   = 6'b001000,
        S_STEP  = 6'b010000,
        S_FRAME = 6'b100000
    } t_state;

    localparam logic [15:0] RATE_LIMIT = 16'h0200;
    localparam int          DIV_STEPS  = 15;

endpackage
`default_nettype wire

FILE: rtl/pfs_ram.sv
// pfs_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/palette_fade_stepper_core.sv
// Palette fade stepper top level: current/target palettes, fade sequencer.
// Depends on pfs_pkg and pfs_ram.
//
// One beat is taken when start is high and busy low; its result appears on
// the o_ ports for one cycle with o_valid, and the receiver cannot stall it.
// Writes and ignored actions answer straight from idle, a read through the
// read state. A frame walks both palettes through the RAM read port, one
// component a cycle. A start walks them twice (max difference, then the
// first frame), with a bit-serial division and a step search between the
// two walks. A tick that runs no frame also answers straight from idle.
`timescale 1ns / 1ps
`default_nettype none
module palette_fade_stepper_core
    import pfs_pkg::*;
#(
    parameter int ENTRIES = 768
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] i_action,
    input  wire logic [9:0] i_index,
    input  wire logic [7:0] i_value,
    input  wire logic [6:0] i_duration,
    output logic            o_valid,
    output logic [7:0]      o_read_value,
    output logic            o_fading,
    output logic            o_frame_applied,
    output logic            o_fade_done
);
    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_vld, n_vld;
    logic [AW-1:0] r_wadr, n_wadr;
    logic          r_is_frame, n_is_frame;
    logic          r_moved, n_moved;
    logic [7:0]    r_maxdiff, n_maxdiff;
    logic [7:0]    r_rem, n_rem;
    logic [3:0]    r_dcnt, n_dcnt;
    logic [15:0]   r_rate, n_rate;
    logic [15:0]   r_base, n_base;
    logic [8:0]    r_step, n_step;
    logic [7:0]    r_frac, n_frac;
    logic [31:0]   r_deadline, n_deadline;
    logic [31:0]   r_tick, n_tick;
    logic          r_active, n_active;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_rd, n_out_rd;
    logic          r_out_app, n_out_app;
    logic          r_out_done, n_out_done;

    logic          cur_we, tgt_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    cur_wdata, cur_rdata, tgt_rdata;

    logic          accept, idx_ok;
    logic [AW-1:0] idx_adr;
    logic [7:0]    diff, new_cur;
    logic [9:0]    up_sum, dn_lim;
    logic [8:0]    rem_sh;
    logic [16:0]   frac_sum;
    logic [31:0]   tick_inc;

    pfs_ram #(.WIDTH(8), .DEPTH(ENTRIES)) u_cur (
        .i_clk  (i_clk),
        .i_we   (cur_we),
        .i_waddr(ram_waddr),
        .i_wdata(cur_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(cur_rdata)
    );

    pfs_ram #(.WIDTH(8), .DEPTH(ENTRIES)) u_tgt (
        .i_clk  (i_clk),
        .i_we   (tgt_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_value),
        .i_raddr(ram_raddr),
        .o_rdata(tgt_rdata)
    );

    assign busy            = (r_state != S_IDLE);
    assign accept          = start && !busy;
    assign idx_ok          = ({22'd0, i_index} < 32'(ENTRIES));
    assign idx_adr         = AW'(i_index);
    assign o_valid         = r_out_valid;
    assign o_read_value    = r_out_rd;
    assign o_fading        = r_active;
    assign o_frame_applied = r_out_app;
    assign o_fade_done     = r_out_done;

    // per-component datapath
    assign diff     = (cur_rdata > tgt_rdata) ? cur_rdata - tgt_rdata : tgt_rdata - cur_rdata;
    assign up_sum   = {2'b00, cur_rdata} + {1'b0, r_step};
    assign dn_lim   = {2'b00, tgt_rdata} + {1'b0, r_step};
    assign rem_sh   = {r_rem, r_rate[14]};
    assign frac_sum = {9'd0, r_frac} + {1'b0, r_rate};
    assign tick_inc = r_tick + 32'd1;

    always_comb begin
        if (cur_rdata < tgt_rdata) begin
            new_cur = (up_sum < {2'b00, tgt_rdata}) ? up_sum[7:0] : tgt_rdata;
        end else if (cur_rdata > tgt_rdata) begin
            new_cur = ({2'b00, cur_rdata} > dn_lim) ? cur_rdata - r_step[7:0] : tgt_rdata;
        end else begin
            new_cur = cur_rdata;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_vld       = 1'b0;
        n_wadr      = r_wadr;
        n_is_frame  = r_is_frame;
        n_moved     = r_moved;
        n_maxdiff   = r_maxdiff;
        n_rem       = r_rem;
        n_dcnt      = r_dcnt;
        n_rate      = r_rate;
        n_base      = r_base;
        n_step      = r_step;
        n_frac      = r_frac;
        n_deadline  = r_deadline;
        n_tick      = r_tick;
        n_active    = r_active;
        n_out_valid = 1'b0;
        n_out_rd    = 8'd0;
        n_out_app   = 1'b0;
        n_out_done  = 1'b0;
        cur_we      = 1'b0;
        tgt_we      = 1'b0;
        ram_waddr   = idx_adr;
        cur_wdata   = i_value;
        ram_raddr   = idx_adr;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_WR_CUR: begin
                            cur_we      = !r_active && idx_ok;
                            n_out_valid = 1'b1;
                        end
                        ACT_WR_TGT: begin
                            tgt_we      = !r_active && idx_ok;
                            n_out_valid = 1'b1;
                        end
                        ACT_START: begin
                            if (r_active) begin
                                n_out_valid = 1'b1;
                            end else begin
                                n_state    = S_SCAN;
                                n_cnt      = '0;
                                n_is_frame = 1'b0;
                                n_maxdiff  = 8'd0;
                            end
                        end
                        ACT_TICK: begin
                            n_tick = tick_inc;
                            if (r_active && tick_inc >= r_deadline) begin
                                n_state = S_FRAME;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        ACT_RD_CUR: begin
                            if (idx_ok) begin
                                n_state = S_READ;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end

            S_READ: begin
                n_out_valid = 1'b1;
                n_out_rd    = cur_rdata;
                n_state     = S_IDLE;
            end

            S_SCAN: begin
                ram_raddr = AW'(r_cnt);
                ram_waddr = r_wadr;
                cur_wdata = new_cur;
                if (r_cnt != CW'(ENTRIES)) begin
                    n_vld  = 1'b1;
                    n_wadr = AW'(r_cnt);
                    n_cnt  = r_cnt + CW'(1);
                end
                if (r_vld) begin
                    if (r_is_frame) begin
                        cur_we = 1'b1;
                        if (cur_rdata != tgt_rdata) begin
                            n_moved = 1'b1;
                        end
                    end else if (diff > r_maxdiff) begin
                        n_maxdiff = diff;
                    end
                end
                if (r_cnt == CW'(ENTRIES) && !r_vld) begin
                    if (r_is_frame) begin
                        n_state     = S_IDLE;
                        n_out_valid = 1'b1;
                        n_out_app   = r_moved;
                        n_out_done  = !r_moved;
                        n_active    = r_moved;
                    end else begin
                        // dividend is duration << 8
                        n_rate = {1'b0, r_base[6:0], 8'd0};
                        n_rem  = 8'd0;
                        n_dcnt = 4'd0;
                        if (r_maxdiff == 8'd0) begin
                            n_base  = n_rate;
                            n_step  = 9'd1;
                            n_state = S_STEP;
                        end else begin
                            n_state = S_DIV;
                        end
                    end
                end
            end

            S_DIV: begin
                if (rem_sh >= {1'b0, r_maxdiff}) begin
                    n_rem  = 8'(rem_sh - {1'b0, r_maxdiff});
                    n_rate = {1'b0, r_rate[13:0], 1'b1};
                end else begin
                    n_rem  = rem_sh[7:0];
                    n_rate = {1'b0, r_rate[13:0], 1'b0};
                end
                n_dcnt = r_dcnt + 4'd1;
                if (r_dcnt == 4'(DIV_STEPS - 1)) begin
                    n_base  = n_rate;
                    n_step  = 9'd1;
                    n_state = S_STEP;
                end
            end

            S_STEP: begin
                if (r_step <= {1'b0, r_maxdiff} && r_rate < RATE_LIMIT) begin
                    n_rate = r_rate + r_base;
                    n_step = r_step + 9'd1;
                end else begin
                    n_frac     = 8'd0;
                    n_deadline = r_tick;
                    n_state    = S_FRAME;
                end
            end

            S_FRAME: begin
                n_deadline = r_deadline + {23'd0, frac_sum[16:8]};
                n_frac     = frac_sum[7:0];
                n_cnt      = '0;
                n_moved    = 1'b0;
                n_is_frame = 1'b1;
                n_state    = S_SCAN;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= 1'b0;
            r_step      <= 9'd0;
            r_rate      <= 16'd0;
            r_frac      <= 8'd0;
            r_deadline  <= 32'd0;
            r_tick      <= 32'd0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vld       <= n_vld;
            r_step      <= n_step;
            r_rate      <= n_rate;
            r_frac      <= n_frac;
            r_deadline  <= n_deadline;
            r_tick      <= n_tick;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    // duration is captured into r_base at start so the beat's fields may change
    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_wadr     <= n_wadr;
        r_is_frame <= n_is_frame;
        r_moved    <= n_moved;
        r_maxdiff  <= n_maxdiff;
        r_rem      <= n_rem;
        r_dcnt     <= n_dcnt;
        r_out_rd   <= n_out_rd;
        r_out_app  <= n_out_app;
        r_out_done <= n_out_done;
        if (accept && i_action == ACT_START) begin
            r_base <= {9'd0, i_duration};
        end else begin
            r_base <= n_base;
        end
    end
endmodule
`default_nettype wire

FILE: test/palette_fade_stepper_core_test.sv
// Testbench for palette_fade_stepper_core: random and directed beats, with a
// scoreboard that predicts the palettes and the fade state and checks each result.
// Depends on pfs_pkg and the palette_fade_stepper_core RTL.
`timescale 1ns / 1ps

module palette_fade_stepper_core_test;
    import pfs_pkg::*;

    localparam int          PAL_SIZE    = 768;
    localparam logic [2:0]  ACT_BAD_LO  = 3'd5;
    localparam logic [2:0]  ACT_BAD_HI  = 3'd7;
    localparam longint      CYCLE_LIMIT = 20_000_000;
    localparam int          RANDOM_BEATS = 750;

    typedef struct packed {
        logic [7:0] read_value;
        logic       fading;
        logic       frame_applied;
        logic       fade_done;
    } fade_result_t;

    class fade_scoreboard;
        logic [7:0]   cur_pal[PAL_SIZE];
        logic [7:0]   tgt_pal[PAL_SIZE];
        logic [8:0]   step_size;
        logic [15:0]  frame_rate;
        logic [7:0]   frac_acc;
        logic [31:0]  deadline;
        logic [31:0]  tick_count;
        bit           fading;
        fade_result_t pending_q[$];
        int           errors;
        int           checked;
        int           fades;
        int           frames;

        function void clear();
            foreach (cur_pal[i]) begin
                cur_pal[i] = '0;
                tgt_pal[i] = '0;
            end
            step_size = '0;
            frame_rate = '0;
            frac_acc = '0;
            deadline = '0;
            tick_count = '0;
            fading = 0;
            pending_q.delete();
            errors = 0;
            checked = 0;
            fades = 0;
            frames = 0;
        endfunction

        function bit frame_moves();
            int sum;
            int c;
            int t;
            bit moved;
            moved = 0;
            sum = int'(frac_acc) + int'(frame_rate);
            deadline = deadline + 32'(sum >> 8);
            frac_acc = sum[7:0];
            for (int i = 0; i < PAL_SIZE; i++) begin
                c = cur_pal[i];
                t = tgt_pal[i];
                if (c < t) begin
                    c = (c + step_size < t) ? c + step_size : t;
                    moved = 1;
                end else if (c > t) begin
                    c = (c > t + step_size) ? c - step_size : t;
                    moved = 1;
                end
                cur_pal[i] = c[7:0];
            end
            frames++;
            return moved;
        endfunction

        function void begin_fade(logic [6:0] duration);
            int maxdiff;
            int d;
            int rate;
            int base;
            int stp;
            maxdiff = 0;
            for (int i = 0; i < PAL_SIZE; i++) begin
                d = int'(cur_pal[i]) - int'(tgt_pal[i]);
                if (d < 0) d = -d;
                if (d > maxdiff) maxdiff = d;
            end
            rate = int'(duration) << 8;
            if (maxdiff != 0) rate = rate / maxdiff;
            base = rate;
            stp = 1;
            while (stp <= maxdiff && rate < int'(RATE_LIMIT)) begin
                rate += base;
                stp++;
            end
            step_size = stp[8:0];
            frame_rate = rate[15:0];
            frac_acc = '0;
            deadline = tick_count;
            fades++;
        endfunction

        function void note_beat(logic [2:0] act, logic [9:0] idx, logic [7:0] val,
                                logic [6:0] duration);
            fade_result_t r;
            r = '0;
            case (act)
                ACT_WR_CUR: if (!fading && idx < PAL_SIZE) cur_pal[idx] = val;
                ACT_WR_TGT: if (!fading && idx < PAL_SIZE) tgt_pal[idx] = val;
                ACT_START: begin
                    if (!fading) begin
                        begin_fade(duration);
                        if (frame_moves()) begin
                            fading = 1;
                            r.frame_applied = 1;
                        end else begin
                            r.fade_done = 1;
                        end
                    end
                end
                ACT_TICK: begin
                    tick_count = tick_count + 1;
                    if (fading && tick_count >= deadline) begin
                        if (frame_moves()) begin
                            r.frame_applied = 1;
                        end else begin
                            fading = 0;
                            r.fade_done = 1;
                        end
                    end
                end
                ACT_RD_CUR: if (idx < PAL_SIZE) r.read_value = cur_pal[idx];
                default: ;
            endcase
            r.fading = fading;
            pending_q.push_back(r);
        endfunction

        function void check_result(fade_result_t got);
            fade_result_t want;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (got.read_value !== want.read_value) begin
                $display("%0t: read_value expected %0d actual %0d", $time,
                         want.read_value, got.read_value);
                errors++;
            end
            if (got.fading !== want.fading) begin
                $display("%0t: fading expected %0d actual %0d", $time,
                         want.fading, got.fading);
                errors++;
            end
            if (got.frame_applied !== want.frame_applied) begin
                $display("%0t: frame_applied expected %0d actual %0d", $time,
                         want.frame_applied, got.frame_applied);
                errors++;
            end
            if (got.fade_done !== want.fade_done) begin
                $display("%0t: fade_done expected %0d actual %0d", $time,
                         want.fade_done, got.fade_done);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [2:0] i_action;
    logic [9:0] i_index;
    logic [7:0] i_value;
    logic [6:0] i_duration;
    logic       o_valid;
    logic [7:0] o_read_value;
    logic       o_fading;
    logic       o_frame_applied;
    logic       o_fade_done;

    fade_scoreboard sb;
    longint         cycles;
    int             beats_sent;
    int             burst_left;

    palette_fade_stepper_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_index        (i_index),
        .i_value        (i_value),
        .i_duration     (i_duration),
        .o_valid        (o_valid),
        .o_read_value   (o_read_value),
        .o_fading       (o_fading),
        .o_frame_applied(o_frame_applied),
        .o_fade_done    (o_fade_done)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("palette_fade_stepper_core test failed");
            $finish;
        end
        if (i_rst_n && o_valid)
            sb.check_result({o_read_value, o_fading, o_frame_applied, o_fade_done});
    end

    task automatic send_beat(logic [2:0] act, logic [9:0] idx, logic [7:0] val,
                             logic [6:0] duration);
        @(negedge i_clk);
        start = 1;
        i_action = act;
        i_index = idx;
        i_value = val;
        i_duration = duration;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_beat(act, idx, val, duration);
        beats_sent++;
    endtask

    // bursty sender: random gaps between bursts of random length
    task automatic paced_beat(logic [2:0] act, logic [9:0] idx, logic [7:0] val,
                              logic [6:0] duration);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0) begin
                @(negedge i_clk);
                start = 0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end
        end
        burst_left--;
        send_beat(act, idx, val, duration);
    endtask

    task automatic noise_beat();
        logic [2:0] act;
        case ($urandom_range(0, 4))
            0: act = ACT_WR_CUR;
            1: act = ACT_WR_TGT;
            2: act = ACT_START;
            3: act = ACT_RD_CUR;
            default: act = 3'($urandom_range(ACT_BAD_LO, ACT_BAD_HI));
        endcase
        paced_beat(act, 10'($urandom_range(0, 1023)), 8'($urandom), 7'($urandom));
    endtask

    task automatic random_fade();
        int n;
        int idx;
        int v;
        int guard;
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
            idx = $urandom_range(0, PAL_SIZE - 1);
            if ($urandom_range(0, 1)) begin
                v = 8'($urandom);
            end else begin
                v = int'(sb.cur_pal[idx]) + $urandom_range(0, 40) - 20;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end
            paced_beat($urandom_range(0, 3) == 0 ? ACT_WR_CUR : ACT_WR_TGT,
                       10'(idx), 8'(v), 7'($urandom));
            if ($urandom_range(0, 7) == 0) noise_beat();
        end
        paced_beat(ACT_START, 10'($urandom), 8'($urandom), 7'($urandom));
        guard = 0;
        while (sb.fading && guard < 3000) begin
            if ($urandom_range(0, 9) == 0) noise_beat();
            else paced_beat(ACT_TICK, 10'($urandom), 8'($urandom), 7'($urandom));
            guard++;
        end
    endtask

    initial begin
        int setup_beats;
        sb = new();
        sb.clear();
        cycles = 0;
        beats_sent = 0;
        burst_left = 0;
        start = 0;
        i_action = ACT_WR_CUR;
        i_index = '0;
        i_value = '0;
        i_duration = '0;
        i_rst_n = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // fill both palettes with equal values so nothing undefined is touched
        for (int i = 0; i < PAL_SIZE; i++) begin
            logic [7:0] v;
            v = 8'($urandom);
            send_beat(ACT_WR_CUR, 10'(i), v, '0);
            send_beat(ACT_WR_TGT, 10'(i), v, '0);
        end

        // directed
        send_beat(ACT_START, '0, '0, 7'd127);
        send_beat(ACT_TICK, '0, '0, '0);
        send_beat(ACT_WR_CUR, 10'd0, 8'd0, '0);
        send_beat(ACT_WR_TGT, 10'd0, 8'd255, '0);
        send_beat(ACT_WR_CUR, 10'd767, 8'd255, '0);
        send_beat(ACT_WR_TGT, 10'd767, 8'd0, '0);
        send_beat(ACT_WR_CUR, 10'd768, 8'd255, '0);
        send_beat(ACT_WR_TGT, 10'd1023, 8'd255, '0);
        send_beat(ACT_RD_CUR, 10'd0, '0, '0);
        send_beat(ACT_RD_CUR, 10'd767, '0, '0);
        send_beat(ACT_RD_CUR, 10'd768, '0, '0);
        send_beat(ACT_RD_CUR, 10'd1023, 8'hff, 7'h7f);
        send_beat(ACT_BAD_LO, 10'd1, 8'hff, 7'h7f);
        send_beat(ACT_BAD_HI, 10'd2, 8'hff, 7'h7f);
        send_beat(ACT_START, '0, '0, 7'd0);
        send_beat(ACT_WR_CUR, 10'd5, 8'd1, '0);
        send_beat(ACT_START, '0, '0, 7'd127);
        send_beat(ACT_RD_CUR, 10'd0, '0, '0);
        while (sb.fading) send_beat(ACT_TICK, '0, '0, '0);
        send_beat(ACT_WR_TGT, 10'd3, 8'(int'(sb.cur_pal[3]) ^ 1), '0);
        send_beat(ACT_START, '0, '0, 7'd127);
        while (sb.fading) send_beat(ACT_TICK, '0, '0, '0);

        setup_beats = beats_sent;
        while (beats_sent < setup_beats + RANDOM_BEATS) random_fade();

        @(negedge i_clk);
        start = 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);

        $display("Covered %0d beats, %0d fades, %0d frames; %0d results checked.",
                 beats_sent, sb.fades, sb.frames, sb.checked);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("palette_fade_stepper_core test passed");
        end else begin
            $display("palette_fade_stepper_core test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/pfs_pkg.sv
rtl/pfs_ram.sv
rtl/palette_fade_stepper_core.sv
test/palette_fade_stepper_core_test.sv
